/* rtl/csm_pkg.sv */
// ---------------------------------------------------------------------------
// csm_pkg: shared types and constants for the clock set menu controller
// Event and mode codes, value limits, and the words carried on the channels.
// ---------------------------------------------------------------------------
package csm_pkg;

    // Event codes carried in the op field
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_RIGHT = 3'd1,
        OP_LEFT  = 3'd2,
        OP_UP    = 3'd3,
        OP_HOLD  = 3'd4
    } op_t;

    // Menu modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_HOUR   = 3'd1,
        MODE_MINUTE = 3'd2,
        MODE_MAX    = 3'd3,
        MODE_MIN    = 3'd4
    } mode_t;

    localparam int unsigned STEP_W = 7;

    localparam logic [7:0]        HOUR_TOP   = 8'd11;
    localparam logic [7:0]        MINUTE_TOP = 8'd59;
    localparam logic [7:0]        BRIGHT_TOP = 8'd255;
    localparam logic [STEP_W-1:0] STEP_RESET = 7'd8;

    // One button event with the values sampled alongside it
    typedef struct packed {
        logic [2:0] op;
        logic [3:0] clock_hour;
        logic [5:0] clock_minute;
        logic [7:0] bright_max_now;
        logic [7:0] bright_min_now;
    } in_word_t;

    // One result per event
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] cursor;
        logic       face_next;
        logic       face_prev;
        logic       time_write;
        logic [3:0] new_hour;
        logic [5:0] new_minute;
        logic       max_write;
        logic       min_write;
        logic [7:0] limit_value;
        logic       save_limits;
    } out_word_t;

    // Menu state held between events
    typedef struct packed {
        mode_t      mode;
        logic [7:0] edit_value;
        logic [3:0] held_hour;
        logic [5:0] held_minute;
    } state_t;

endpackage

/* rtl/csm_chan_if.sv */
// ---------------------------------------------------------------------------
// csm_chan_if: valid/ready channel
// Carries one payload word per handshake; the source drives valid and payload.
// ---------------------------------------------------------------------------
interface csm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/csm_step.sv */
// ---------------------------------------------------------------------------
// csm_step: menu update for one event
// Computes the next menu state and the result word from the current state, the event word and the brightness step.
// ---------------------------------------------------------------------------
module csm_step (
    input  csm_pkg::state_t                st,
    input  csm_pkg::in_word_t              evt_word,
    input  logic [csm_pkg::STEP_W-1:0]     step,
    output csm_pkg::state_t                st_next,
    output csm_pkg::out_word_t             res_word
);

    // Step up with wrap to zero past the top
    function automatic logic [7:0] wrap_up(input logic [7:0] v, input logic [7:0] top);
        begin
            wrap_up = (v >= top) ? 8'd0 : v + 8'd1;
        end
    endfunction

    // Step down with wrap to the top below zero
    function automatic logic [7:0] wrap_down(input logic [7:0] v, input logic [7:0] top);
        begin
            wrap_down = (v == 8'd0 || v > top) ? top : v - 8'd1;
        end
    endfunction

    // Add with saturation at full scale
    function automatic logic [7:0] sat_add(input logic [7:0] v,
                                           input logic [csm_pkg::STEP_W-1:0] d);
        logic [8:0] sum;
        begin
            sum = {1'b0, v} + {2'b00, d};
            sat_add = (sum > {1'b0, csm_pkg::BRIGHT_TOP}) ? csm_pkg::BRIGHT_TOP : sum[7:0];
        end
    endfunction

    // Subtract with saturation at zero
    function automatic logic [7:0] sat_sub(input logic [7:0] v,
                                           input logic [csm_pkg::STEP_W-1:0] d);
        logic [7:0] d8;
        begin
            d8 = {1'b0, d};
            sat_sub = (d8 >= v) ? 8'd0 : v - d8;
        end
    endfunction

    logic [3:0] hour_clamped;
    logic [5:0] minute_clamped;
    logic [7:0] bright_stepped;
    logic       is_step;

    // Clamp the sampled time into range and step the brightness value
    always_comb
    begin
        hour_clamped   = ({4'd0, evt_word.clock_hour} > csm_pkg::HOUR_TOP)
                         ? csm_pkg::HOUR_TOP[3:0] : evt_word.clock_hour;
        minute_clamped = ({2'd0, evt_word.clock_minute} > csm_pkg::MINUTE_TOP)
                         ? csm_pkg::MINUTE_TOP[5:0] : evt_word.clock_minute;
        is_step        = (evt_word.op == csm_pkg::OP_RIGHT) || (evt_word.op == csm_pkg::OP_LEFT);
        bright_stepped = (evt_word.op == csm_pkg::OP_RIGHT) ? sat_add(st.edit_value, step)
                                                            : sat_sub(st.edit_value, step);
    end

    // Advance the menu for this event
    always_comb
    begin
        st_next  = st;
        res_word = '0;

        unique case (st.mode)
            csm_pkg::MODE_HOUR:
            begin
                unique case (evt_word.op)
                    csm_pkg::OP_RIGHT: st_next.edit_value = wrap_up(st.edit_value,
                                                                    csm_pkg::HOUR_TOP);
                    csm_pkg::OP_LEFT:  st_next.edit_value = wrap_down(st.edit_value,
                                                                      csm_pkg::HOUR_TOP);
                    csm_pkg::OP_UP:
                    begin
                        st_next.held_hour  = st.edit_value[3:0];
                        st_next.edit_value = {2'b00, st.held_minute};
                        st_next.mode       = csm_pkg::MODE_MINUTE;
                    end
                    csm_pkg::OP_HOLD:
                    begin
                        st_next.edit_value = evt_word.bright_max_now;
                        st_next.mode       = csm_pkg::MODE_MAX;
                    end
                    default: ;
                endcase
            end
            csm_pkg::MODE_MINUTE:
            begin
                unique case (evt_word.op)
                    csm_pkg::OP_RIGHT: st_next.edit_value = wrap_up(st.edit_value,
                                                                    csm_pkg::MINUTE_TOP);
                    csm_pkg::OP_LEFT:  st_next.edit_value = wrap_down(st.edit_value,
                                                                      csm_pkg::MINUTE_TOP);
                    csm_pkg::OP_UP:
                    begin
                        st_next.held_minute = st.edit_value[5:0];
                        st_next.mode        = csm_pkg::MODE_NORMAL;
                        res_word.time_write = 1'b1;
                        res_word.new_hour   = st.held_hour;
                        res_word.new_minute = st.edit_value[5:0];
                    end
                    default: ;
                endcase
            end
            csm_pkg::MODE_MAX,
            csm_pkg::MODE_MIN:
            begin
                if (is_step)
                begin
                    st_next.edit_value   = bright_stepped;
                    res_word.limit_value = bright_stepped;
                    res_word.max_write   = (st.mode == csm_pkg::MODE_MAX);
                    res_word.min_write   = (st.mode == csm_pkg::MODE_MIN);
                end
                else if (evt_word.op == csm_pkg::OP_UP)
                begin
                    if (st.mode == csm_pkg::MODE_MAX)
                    begin
                        st_next.edit_value = evt_word.bright_min_now;
                        st_next.mode       = csm_pkg::MODE_MIN;
                    end
                    else
                    begin
                        st_next.edit_value = evt_word.bright_max_now;
                        st_next.mode       = csm_pkg::MODE_MAX;
                    end
                end
                else if (evt_word.op == csm_pkg::OP_HOLD)
                begin
                    res_word.save_limits = 1'b1;
                    st_next.mode         = csm_pkg::MODE_NORMAL;
                end
            end
            default:
            begin
                st_next.mode = csm_pkg::MODE_NORMAL;
                unique case (evt_word.op)
                    csm_pkg::OP_RIGHT: res_word.face_next = 1'b1;
                    csm_pkg::OP_LEFT:  res_word.face_prev = 1'b1;
                    csm_pkg::OP_HOLD:
                    begin
                        st_next.held_hour   = hour_clamped;
                        st_next.held_minute = minute_clamped;
                        st_next.edit_value  = {4'd0, hour_clamped};
                        st_next.mode        = csm_pkg::MODE_HOUR;
                    end
                    default: ;
                endcase
            end
        endcase

        // Report the mode after the event; cursor reads zero in normal mode
        res_word.mode   = st_next.mode;
        res_word.cursor = (st_next.mode == csm_pkg::MODE_NORMAL) ? 8'd0 : st_next.edit_value;
    end

endmodule

/* rtl/clock_set_menu_fsm_core.sv */
// ---------------------------------------------------------------------------
// clock_set_menu_fsm_core: five-mode menu controller for a 12-hour clock
// Takes button event words and returns one result word per event.
// ---------------------------------------------------------------------------
// Latency: a result word is valid in the cycle after its event word is taken.
// Throughput: one event word per cycle unless the result channel stalls; the
// output register is refilled in the same cycle that its word is taken downstream.
// Reset: menu returns to normal mode with zeroed cursor and held time, the
// output register empties, and the brightness step returns to 8.
// ---------------------------------------------------------------------------
module clock_set_menu_fsm_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [csm_pkg::STEP_W-1:0]     cfg_wdata,
    csm_chan_if.sink                       evt,
    csm_chan_if.source                     res
);

    csm_pkg::state_t                state_reg;
    csm_pkg::state_t                state_next;
    csm_pkg::out_word_t             res_word_reg;
    csm_pkg::out_word_t             res_word_next;
    logic                           res_valid_reg;
    logic [csm_pkg::STEP_W-1:0]     step_reg;
    logic                           evt_take;

    // Take a new word whenever the output register is free or draining
    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_take  = evt.valid && evt.ready;

    csm_step u_step (
        .st       (state_reg),
        .evt_word (evt.payload),
        .step     (step_reg),
        .st_next  (state_next),
        .res_word (res_word_next)
    );

    // Hold the brightness step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= csm_pkg::STEP_RESET;
        else if (cfg_we)
            step_reg <= cfg_wdata;
    end

    // Advance the menu state on each taken word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= csm_pkg::MODE_NORMAL;
            state_reg.edit_value  <= '0;
            state_reg.held_hour   <= '0;
            state_reg.held_minute <= '0;
        end
        else if (evt_take)
            state_reg <= state_next;
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (evt_take)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (evt_take)
            res_word_reg <= res_word_next;
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_word_reg;

    // A taken word always shows up at the output next cycle
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_take |=> res.valid)
        else $error("taken event word gave no result");

    // No more than one strobe per result
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> $onehot0({res.payload.face_next, res.payload.face_prev,
                                res.payload.time_write, res.payload.max_write,
                                res.payload.min_write, res.payload.save_limits}))
        else $error("more than one strobe in a result");

    // A time write or a save always lands back in normal mode
    a_exit_to_normal: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.payload.time_write || res.payload.save_limits)
        |-> (res.payload.mode == csm_pkg::MODE_NORMAL) && (state_reg.mode == csm_pkg::MODE_NORMAL))
        else $error("exit strobe without return to normal mode");

    // The reported mode tracks the menu state
    a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.payload.mode == state_reg.mode))
        else $error("reported mode differs from menu state");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the clock set menu controller
// Drives button event words through the valid/ready channel, random gaps on
// both sides, tracks the menu state in a scoreboard class and checks every
// result word field by field. The brightness step is rewritten between phases.
// ---------------------------------------------------------------------------
module tb_top;
    import csm_pkg::*;

    localparam int PHASE_EVENTS = 155;
    localparam int IDLE_LIMIT   = 1000;

    // Menu tracker: mirrors the controller state and checks its result words
    class menu_checker;
        mode_t           mode;
        logic [7:0]      edit_value;
        logic [3:0]      held_hour;
        logic [5:0]      held_minute;
        logic [STEP_W-1:0] step;
        out_word_t       expected_words[$];
        int              mismatches;
        int              words_seen;
        int              time_writes;
        int              limit_writes;
        int              saves;

        function new();
            mode          = MODE_NORMAL;
            edit_value    = '0;
            held_hour     = '0;
            held_minute   = '0;
            step          = STEP_RESET;
            mismatches    = 0;
            words_seen    = 0;
            time_writes   = 0;
            limit_writes  = 0;
            saves         = 0;
        endfunction

        function void set_step(logic [STEP_W-1:0] v);
            step = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Advance the menu by one event and queue the word it should produce
        function void note_event(in_word_t w);
            out_word_t  e;
            logic [8:0] sum;
            e = '0;
            case (mode)
                MODE_HOUR:
                begin
                    if (w.op == OP_RIGHT)
                        edit_value = (edit_value >= HOUR_TOP) ? 8'd0 : edit_value + 8'd1;
                    else if (w.op == OP_LEFT)
                        edit_value = (edit_value == 0 || edit_value > HOUR_TOP) ?
                                     HOUR_TOP : edit_value - 8'd1;
                    else if (w.op == OP_UP)
                    begin
                        held_hour  = edit_value[3:0];
                        edit_value = {2'b00, held_minute};
                        mode       = MODE_MINUTE;
                    end
                    else if (w.op == OP_HOLD)
                    begin
                        edit_value = w.bright_max_now;
                        mode       = MODE_MAX;
                    end
                end
                MODE_MINUTE:
                begin
                    if (w.op == OP_RIGHT)
                        edit_value = (edit_value >= MINUTE_TOP) ? 8'd0 : edit_value + 8'd1;
                    else if (w.op == OP_LEFT)
                        edit_value = (edit_value == 0 || edit_value > MINUTE_TOP) ?
                                     MINUTE_TOP : edit_value - 8'd1;
                    else if (w.op == OP_UP)
                    begin
                        held_minute  = edit_value[5:0];
                        e.time_write = 1'b1;
                        e.new_hour   = held_hour;
                        e.new_minute = held_minute;
                        mode         = MODE_NORMAL;
                    end
                end
                MODE_MAX, MODE_MIN:
                begin
                    if (w.op == OP_RIGHT || w.op == OP_LEFT)
                    begin
                        // Step the limit, saturating at both ends
                        if (w.op == OP_RIGHT)
                        begin
                            sum        = {1'b0, edit_value} + {2'b00, step};
                            edit_value = (sum > {1'b0, BRIGHT_TOP}) ? BRIGHT_TOP : sum[7:0];
                        end
                        else
                            edit_value = ({1'b0, step} >= edit_value) ? 8'd0 :
                                         edit_value - {1'b0, step};
                        e.limit_value = edit_value;
                        if (mode == MODE_MAX)
                            e.max_write = 1'b1;
                        else
                            e.min_write = 1'b1;
                    end
                    else if (w.op == OP_UP)
                    begin
                        if (mode == MODE_MAX)
                        begin
                            edit_value = w.bright_min_now;
                            mode       = MODE_MIN;
                        end
                        else
                        begin
                            edit_value = w.bright_max_now;
                            mode       = MODE_MAX;
                        end
                    end
                    else if (w.op == OP_HOLD)
                    begin
                        e.save_limits = 1'b1;
                        mode          = MODE_NORMAL;
                    end
                end
                default:
                begin
                    mode = MODE_NORMAL;
                    if (w.op == OP_RIGHT)
                        e.face_next = 1'b1;
                    else if (w.op == OP_LEFT)
                        e.face_prev = 1'b1;
                    else if (w.op == OP_HOLD)
                    begin
                        // Sample the time, clamping out-of-range values
                        held_hour   = ({4'd0, w.clock_hour} > HOUR_TOP) ?
                                      HOUR_TOP[3:0] : w.clock_hour;
                        held_minute = ({2'd0, w.clock_minute} > MINUTE_TOP) ?
                                      MINUTE_TOP[5:0] : w.clock_minute;
                        edit_value  = {4'd0, held_hour};
                        mode        = MODE_HOUR;
                    end
                end
            endcase
            e.mode   = mode;
            e.cursor = (mode == MODE_NORMAL) ? 8'd0 : edit_value;
            time_writes  += e.time_write;
            limit_writes += e.max_write + e.min_write;
            saves        += e.save_limits;
            expected_words.push_back(e);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Check one result word against the oldest expectation
        function void check_word(out_word_t got);
            out_word_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            e = expected_words.pop_front();
            words_seen++;
            compare_field("mode",        e.mode,        got.mode);
            compare_field("cursor",      e.cursor,      got.cursor);
            compare_field("face_next",   e.face_next,   got.face_next);
            compare_field("face_prev",   e.face_prev,   got.face_prev);
            compare_field("time_write",  e.time_write,  got.time_write);
            compare_field("new_hour",    e.new_hour,    got.new_hour);
            compare_field("new_minute",  e.new_minute,  got.new_minute);
            compare_field("max_write",   e.max_write,   got.max_write);
            compare_field("min_write",   e.min_write,   got.min_write);
            compare_field("limit_value", e.limit_value, got.limit_value);
            compare_field("save_limits", e.save_limits, got.save_limits);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;
    logic              no_idle;
    int                idle_cycles;
    int                cfg_writes;
    menu_checker       board;

    csm_chan_if #(.payload_t(in_word_t))  evt_if ();
    csm_chan_if #(.payload_t(out_word_t)) res_if ();

    clock_set_menu_fsm_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .evt       (evt_if),
        .res       (res_if)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap length: mostly none, some short, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function in_word_t make_word(logic [2:0] op, logic [3:0] hr, logic [5:0] mn,
                                 logic [7:0] bmax, logic [7:0] bmin);
        in_word_t w;
        w.op             = op;
        w.clock_hour     = hr;
        w.clock_minute   = mn;
        w.bright_max_now = bmax;
        w.bright_min_now = bmin;
        return w;
    endfunction

    // Random event, weighted toward the ones that move through the menu
    function in_word_t random_word();
        int         r;
        logic [2:0] op;
        logic [7:0] bmax;
        logic [7:0] bmin;
        r = $urandom_range(0, 99);
        if (r < 38)
            op = OP_RIGHT;
        else if (r < 62)
            op = OP_LEFT;
        else if (r < 78)
            op = OP_UP;
        else if (r < 90)
            op = OP_HOLD;
        else if (r < 95)
            op = OP_NONE;
        else
            op = 3'(OP_HOLD) + 3'($urandom_range(1, 3));
        bmax = ($urandom_range(0, 9) == 0) ? BRIGHT_TOP : 8'($urandom);
        bmin = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        return make_word(op, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                         bmax, bmin);
    endfunction

    // Present one event word after a gap and hold it until taken
    task automatic send_event(input in_word_t w);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            evt_if.valid <= 1'b0;
        end
        @(negedge clk);
        evt_if.valid   <= 1'b1;
        evt_if.payload <= w;
        do
            @(posedge clk);
        while (!(evt_if.valid && evt_if.ready));
        board.note_event(w);
    endtask

    // Drop valid and wait for every outstanding result word
    task automatic drain();
        @(negedge clk);
        evt_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write the brightness step while the menu is idle
    task automatic write_step(input logic [STEP_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_step(v);
        cfg_writes++;
    endtask

    // Receiver side: runs of ready broken by stalls
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 40))
            begin
                @(negedge clk);
                res_if.ready <= 1'b1;
            end
            repeat (pick_gap())
            begin
                @(negedge clk);
                res_if.ready <= 1'b0;
            end
        end
    end

    // Check every result word taken
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            board.check_word(res_if.payload);
    end

    // Stop the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("clock_set_menu_fsm_core verification failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        in_word_t          directed[$];
        logic [STEP_W-1:0] steps[6];

        board          = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        no_idle        = 1'b0;
        cfg_writes     = 0;
        evt_if.valid   = 1'b0;
        evt_if.payload = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk through every mode, wrap, clamp and saturation case
        directed.push_back(make_word(OP_NONE,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_RIGHT, 4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_LEFT,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_UP,    4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(3'(OP_HOLD) + 3'd3, 4'd0, 6'd0, 8'd0, 8'd0));
        directed.push_back(make_word(OP_HOLD,  4'd15, 6'd63, 8'd0,   8'd0));
        directed.push_back(make_word(OP_RIGHT, 4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_LEFT,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(3'(OP_HOLD) + 3'd1, 4'd0, 6'd0, 8'd0, 8'd0));
        directed.push_back(make_word(OP_UP,    4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_RIGHT, 4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_LEFT,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_HOLD,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_UP,    4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_HOLD,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_HOLD,  4'd5,  6'd30, 8'd255, 8'd0));
        directed.push_back(make_word(OP_RIGHT, 4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_UP,    4'd0,  6'd0,  8'd255, 8'd0));
        directed.push_back(make_word(OP_LEFT,  4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_RIGHT, 4'd0,  6'd0,  8'd0,   8'd0));
        directed.push_back(make_word(OP_UP,    4'd9,  6'd17, 8'd100, 8'd255));
        directed.push_back(make_word(OP_HOLD,  4'd0,  6'd0,  8'd0,   8'd0));
        foreach (directed[i])
            send_event(directed[i]);

        // Random phases, each with its own brightness step
        steps[0] = 7'd1;
        steps[1] = 7'd64;
        steps[2] = 7'd0;
        steps[3] = 7'd127;
        steps[4] = 7'($urandom_range(2, 63));
        steps[5] = STEP_RESET;
        foreach (steps[p])
        begin
            write_step(steps[p]);
            no_idle = (p == 2);
            repeat (PHASE_EVENTS)
                send_event(random_word());
        end
        no_idle = 1'b0;

        drain();
        $display("Checked %0d result words over %0d step settings: %0d time writes,",
                 board.words_seen, cfg_writes, board.time_writes);
        $display("%0d limit writes and %0d limit saves seen.",
                 board.limit_writes, board.saves);
        if (board.mismatches == 0)
            $display("clock_set_menu_fsm_core verification clean");
        else
            $display("clock_set_menu_fsm_core verification failed");
        $finish;
    end

endmodule
